// ===== hw/rtl/tpsik_pkg.sv =====
// Shared types, widths and constants for the tilt plate servo inverse kinematics block.
package tpsik_pkg;

	localparam int CORDIC_N   = 16;
	localparam int DIV_STEPS  = 30;
	localparam int SQRT_STEPS = 31;

	localparam int ZW   = 25;
	localparam int XW   = 34;
	localparam int HW   = 27;
	localparam int NW   = 55;
	localparam int AW   = 54;
	localparam int QW   = 30;
	localparam int ARGW = 32;
	localparam int SW   = 62;
	localparam int ATW  = 22;

	localparam int TOP_LAT  = CORDIC_N + 4;
	localparam int LEG_LAT  = 4 + DIV_STEPS + 3 + SQRT_STEPS + CORDIC_N + 1;
	localparam int PIPE_LAT = TOP_LAT + LEG_LAT;

	localparam logic [ATW-1:0] ATAN_Q16 [CORDIC_N] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115
	};

	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [29:0] HALF_SQRT3 = 30'd929887697;
	localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
	localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
	localparam logic signed [ARGW-1:0] ONE_Q30 = ARGW'(64'd1 << 30);
	localparam logic [SW-1:0] SQ_ONE = SW'(1) << (SW - 2);

	localparam int TILT_LIMIT_DEG = 45;
	localparam logic signed [15:0] TILT_LIMIT = 16'(TILT_LIMIT_DEG * 256);

	localparam logic [15:0] RST_JOINT_RADIUS = 16'd10240;
	localparam logic [15:0] RST_CRANK_LENGTH = 16'd8960;
	localparam logic [15:0] RST_ROD_LENGTH   = 16'd16640;
	localparam logic [15:0] RST_PLATE_HEIGHT = 16'd20480;

	typedef enum logic [1:0] {
		CFG_JOINT_RADIUS = 2'd0,
		CFG_CRANK_LENGTH = 2'd1,
		CFG_ROD_LENGTH   = 2'd2,
		CFG_PLATE_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TILT    = 2'd1,
		ST_UNREACH = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] servo_a_angle;
		logic signed [15:0] servo_b_angle;
		logic signed [15:0] servo_c_angle;
		status_t            status;
	} servo_t;

	typedef struct packed {
		logic [15:0] crank_length;
		logic [31:0] crank_sq;
		logic [31:0] rod_sq;
	} leg_cfg_t;

	typedef struct packed {
		logic signed [15:0] angle;
		logic               bad;
	} leg_res_t;

endpackage

// ===== hw/rtl/tpsik_leg.sv =====
// One leg: law of cosines, restoring divide, square root and arcsine CORDIC pipeline.
module tpsik_leg (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [tpsik_pkg::HW-1:0]  h,
	input  tpsik_pkg::leg_cfg_t              cfg,
	output tpsik_pkg::leg_res_t              res
);
	logic signed [2*tpsik_pkg::HW-1:0] hh_s1;
	logic signed [tpsik_pkg::HW+16:0]  clh_s1;
	logic signed [32:0]                lsq_s1;
	logic signed [tpsik_pkg::NW-1:0]   num_s2;
	logic signed [tpsik_pkg::NW-1:0]   den_s2;
	logic [tpsik_pkg::AW-1:0]          an_s3;
	logic [tpsik_pkg::AW-1:0]          ad_s3;
	logic                              neg_s3;
	logic                              pos_s3;

	logic [tpsik_pkg::AW-1:0] dr_s   [tpsik_pkg::DIV_STEPS+1];
	logic [tpsik_pkg::AW-1:0] dd_s   [tpsik_pkg::DIV_STEPS+1];
	logic [tpsik_pkg::QW-1:0] dq_s   [tpsik_pkg::DIV_STEPS+1];
	logic                     dsat_s [tpsik_pkg::DIV_STEPS+1];
	logic                     dsn_s  [tpsik_pkg::DIV_STEPS+1];
	logic                     dbad_s [tpsik_pkg::DIV_STEPS+1];
	logic                     dneg_s [tpsik_pkg::DIV_STEPS+1];

	logic signed [tpsik_pkg::ARGW-1:0]   quo;
	logic signed [tpsik_pkg::ARGW-1:0]   arg_s35;
	logic                                bad_s35;
	logic signed [2*tpsik_pkg::ARGW-1:0] sqp;
	logic [tpsik_pkg::SW-1:0]            sq_s36;
	logic signed [tpsik_pkg::ARGW-1:0]   arg_s36;
	logic                                bad_s36;

	logic [tpsik_pkg::SW-1:0]          sv_s [tpsik_pkg::SQRT_STEPS+1];
	logic [tpsik_pkg::SW-1:0]          sr_s [tpsik_pkg::SQRT_STEPS+1];
	logic signed [tpsik_pkg::ARGW-1:0] sa_s [tpsik_pkg::SQRT_STEPS+1];
	logic                              sb_s [tpsik_pkg::SQRT_STEPS+1];

	logic signed [tpsik_pkg::XW-1:0] cx_s [1:tpsik_pkg::CORDIC_N];
	logic signed [tpsik_pkg::XW-1:0] cy_s [1:tpsik_pkg::CORDIC_N];
	logic signed [tpsik_pkg::ZW-1:0] cz_s [1:tpsik_pkg::CORDIC_N];
	logic                            cb_s [1:tpsik_pkg::CORDIC_N];

	logic signed [tpsik_pkg::ZW-1:0] zr;
	tpsik_pkg::leg_res_t             res_s85;

	// squares and crank-height product
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1  <= h * h;
			clh_s1 <= $signed({1'b0, cfg.crank_length}) * h;
			lsq_s1 <= $signed({1'b0, cfg.crank_sq}) - $signed({1'b0, cfg.rod_sq});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= tpsik_pkg::NW'(hh_s1) + (tpsik_pkg::NW'(lsq_s1) <<< 16);
			den_s2 <= tpsik_pkg::NW'(clh_s1) <<< 9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s3  <= tpsik_pkg::AW'(num_s2[tpsik_pkg::NW-1] ? -num_s2 : num_s2);
			ad_s3  <= tpsik_pkg::AW'(den_s2[tpsik_pkg::NW-1] ? -den_s2 : den_s2);
			neg_s3 <= num_s2[tpsik_pkg::NW-1] ^ den_s2[tpsik_pkg::NW-1];
			pos_s3 <= !num_s2[tpsik_pkg::NW-1];
		end
	end

	// saturation decision, divider entry
	always_ff @(posedge clk) begin
		if (en) begin
			dr_s[0]   <= an_s3;
			dd_s[0]   <= ad_s3;
			dq_s[0]   <= '0;
			dsat_s[0] <= (ad_s3 == '0) || (an_s3 >= ad_s3);
			dsn_s[0]  <= (ad_s3 == '0) ? !pos_s3 : neg_s3;
			dbad_s[0] <= (ad_s3 == '0) || (an_s3 > ad_s3);
			dneg_s[0] <= neg_s3;
		end
	end

	for (genvar k = 0; k < tpsik_pkg::DIV_STEPS; k++) begin : g_div
		logic [tpsik_pkg::AW-1:0] r2;
		assign r2 = {dr_s[k][tpsik_pkg::AW-2:0], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				if (r2 >= dd_s[k]) begin
					dr_s[k+1] <= r2 - dd_s[k];
					dq_s[k+1] <= {dq_s[k][tpsik_pkg::QW-2:0], 1'b1};
				end else begin
					dr_s[k+1] <= r2;
					dq_s[k+1] <= {dq_s[k][tpsik_pkg::QW-2:0], 1'b0};
				end
				dd_s[k+1]   <= dd_s[k];
				dsat_s[k+1] <= dsat_s[k];
				dsn_s[k+1]  <= dsn_s[k];
				dbad_s[k+1] <= dbad_s[k];
				dneg_s[k+1] <= dneg_s[k];
			end
		end
	end

	assign quo = $signed({{(tpsik_pkg::ARGW-tpsik_pkg::QW){1'b0}},
		dq_s[tpsik_pkg::DIV_STEPS]});

	always_ff @(posedge clk) begin
		if (en) begin
			if (dsat_s[tpsik_pkg::DIV_STEPS]) begin
				arg_s35 <= dsn_s[tpsik_pkg::DIV_STEPS] ? -tpsik_pkg::ONE_Q30 :
					tpsik_pkg::ONE_Q30;
			end else begin
				arg_s35 <= dneg_s[tpsik_pkg::DIV_STEPS] ? -quo : quo;
			end
			bad_s35 <= dbad_s[tpsik_pkg::DIV_STEPS];
		end
	end

	assign sqp = arg_s35 * arg_s35;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s36  <= sqp[tpsik_pkg::SW-1:0];
			arg_s36 <= arg_s35;
			bad_s36 <= bad_s35;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s[0] <= tpsik_pkg::SQ_ONE - sq_s36;
			sr_s[0] <= '0;
			sa_s[0] <= arg_s36;
			sb_s[0] <= bad_s36;
		end
	end

	// digit-by-digit square root, two radicand bits a stage
	for (genvar k = 0; k < tpsik_pkg::SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [tpsik_pkg::SW-1:0] BIT = tpsik_pkg::SQ_ONE >> (2 * k);
		logic [tpsik_pkg::SW-1:0] t;
		assign t = sr_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (sv_s[k] >= t) begin
					sv_s[k+1] <= sv_s[k] - t;
					sr_s[k+1] <= (sr_s[k] >> 1) + BIT;
				end else begin
					sv_s[k+1] <= sv_s[k];
					sr_s[k+1] <= sr_s[k] >> 1;
				end
				sa_s[k+1] <= sa_s[k];
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	// vectoring CORDIC: angle of (sqrt(1-arg^2), arg)
	for (genvar k = 0; k < tpsik_pkg::CORDIC_N; k++) begin : g_asin
		localparam logic signed [tpsik_pkg::ZW-1:0] ATZ =
			$signed({{(tpsik_pkg::ZW-tpsik_pkg::ATW){1'b0}}, tpsik_pkg::ATAN_Q16[k]});
		logic signed [tpsik_pkg::XW-1:0] xin;
		logic signed [tpsik_pkg::XW-1:0] yin;
		logic signed [tpsik_pkg::ZW-1:0] zin;
		logic                            bin;
		if (k == 0) begin : g_first
			assign xin = $signed(tpsik_pkg::XW'(sr_s[tpsik_pkg::SQRT_STEPS]));
			assign yin = tpsik_pkg::XW'(sa_s[tpsik_pkg::SQRT_STEPS]);
			assign zin = '0;
			assign bin = sb_s[tpsik_pkg::SQRT_STEPS];
		end else begin : g_rest
			assign xin = cx_s[k];
			assign yin = cy_s[k];
			assign zin = cz_s[k];
			assign bin = cb_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (yin[tpsik_pkg::XW-1]) begin
					cx_s[k+1] <= xin - (yin >>> k);
					cy_s[k+1] <= yin + (xin >>> k);
					cz_s[k+1] <= zin - ATZ;
				end else begin
					cx_s[k+1] <= xin + (yin >>> k);
					cy_s[k+1] <= yin - (xin >>> k);
					cz_s[k+1] <= zin + ATZ;
				end
				cb_s[k+1] <= bin;
			end
		end
	end

	assign zr = cz_s[tpsik_pkg::CORDIC_N] + tpsik_pkg::ZW'(128);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s85.angle <= zr[23:8];
			res_s85.bad   <= cb_s[tpsik_pkg::CORDIC_N];
		end
	end

	assign res = res_s85;

endmodule

// ===== hw/rtl/tilt_plate_servo_inverse_kinematics.sv =====
// Top level: pose sine CORDICs, leg heights, three leg pipelines and the result word register.
// Throughput: one word per cycle while the output is not stalled; the pipeline is 105 stages plus the output register.
// A stalled output word freezes every stage and stalls the input until it is taken.
// Reset clears all valid bits and loads the default lengths; no clearing pass.
module tilt_plate_servo_inverse_kinematics (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pose_valid,
	output logic                pose_stall,
	input  tpsik_pkg::pose_t    pose,
	output logic                servo_valid,
	input  logic                servo_stall,
	output tpsik_pkg::servo_t   servo,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	logic [15:0] joint_radius_q;
	logic [15:0] crank_length_q;
	logic [15:0] rod_length_q;
	logic [15:0] plate_height_q;
	logic [31:0] crank_sq_q;
	logic [31:0] rod_sq_q;

	logic en;
	logic acc;
	logic tilt;

	logic [tpsik_pkg::PIPE_LAT-1:0] vld_s;
	logic [tpsik_pkg::PIPE_LAT-1:0] tilt_s;

	logic signed [15:0] ang [2];
	logic signed [tpsik_pkg::XW-1:0] sx_s [2][tpsik_pkg::CORDIC_N+1];
	logic signed [tpsik_pkg::XW-1:0] sy_s [2][tpsik_pkg::CORDIC_N+1];
	logic signed [tpsik_pkg::ZW-1:0] sz_s [2][tpsik_pkg::CORDIC_N+1];

	logic signed [50:0]               rprod [2];
	logic signed [tpsik_pkg::HW-1:0]  rs_s18 [2];
	logic signed [57:0]               sprod;
	logic signed [tpsik_pkg::HW-1:0]  side_s19;
	logic signed [tpsik_pkg::HW-1:0]  half_s19;
	logic signed [tpsik_pkg::HW-1:0]  rsa_s19;
	logic signed [tpsik_pkg::HW-1:0]  base;
	logic signed [tpsik_pkg::HW-1:0]  h_s20 [3];

	tpsik_pkg::leg_cfg_t leg_cfg;
	tpsik_pkg::leg_res_t leg_res [3];
	tpsik_pkg::status_t  status_c;

	function automatic logic signed [tpsik_pkg::ZW-1:0] fold(input logic signed [15:0] a);
		logic signed [tpsik_pkg::ZW-1:0] z;
		z = {{(tpsik_pkg::ZW-24){a[15]}}, a, 8'd0};
		if (z > tpsik_pkg::DEG90) begin
			fold = tpsik_pkg::DEG180 - z;
		end else if (z < -tpsik_pkg::DEG90) begin
			fold = -tpsik_pkg::DEG180 - z;
		end else begin
			fold = z;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_radius_q <= tpsik_pkg::RST_JOINT_RADIUS;
			crank_length_q <= tpsik_pkg::RST_CRANK_LENGTH;
			rod_length_q   <= tpsik_pkg::RST_ROD_LENGTH;
			plate_height_q <= tpsik_pkg::RST_PLATE_HEIGHT;
		end else if (cfg_we) begin
			unique case (tpsik_pkg::cfg_idx_t'(cfg_index))
				tpsik_pkg::CFG_JOINT_RADIUS: joint_radius_q <= cfg_data;
				tpsik_pkg::CFG_CRANK_LENGTH: crank_length_q <= cfg_data;
				tpsik_pkg::CFG_ROD_LENGTH:   rod_length_q   <= cfg_data;
				tpsik_pkg::CFG_PLATE_HEIGHT: plate_height_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		crank_sq_q <= 32'(crank_length_q) * 32'(crank_length_q);
		rod_sq_q   <= 32'(rod_length_q) * 32'(rod_length_q);
	end

	assign leg_cfg = '{crank_length: crank_length_q, crank_sq: crank_sq_q, rod_sq: rod_sq_q};

	assign en         = !(servo_valid && servo_stall);
	assign pose_stall = !en;
	assign acc        = pose_valid && en;

	assign tilt = (pose.roll_angle > tpsik_pkg::TILT_LIMIT) ||
		(pose.roll_angle < -tpsik_pkg::TILT_LIMIT) ||
		(pose.pitch_angle > tpsik_pkg::TILT_LIMIT) ||
		(pose.pitch_angle < -tpsik_pkg::TILT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[tpsik_pkg::PIPE_LAT-2:0], acc};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tilt_s <= {tilt_s[tpsik_pkg::PIPE_LAT-2:0], tilt};
		end
	end

	assign ang[0] = pose.roll_angle;
	assign ang[1] = pose.pitch_angle;

	// rotation CORDIC for sine of roll (lane 0) and pitch (lane 1)
	for (genvar l = 0; l < 2; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				sx_s[l][0] <= tpsik_pkg::CORDIC_GAIN;
				sy_s[l][0] <= '0;
				sz_s[l][0] <= fold(ang[l]);
			end
		end
		for (genvar i = 0; i < tpsik_pkg::CORDIC_N; i++) begin : g_rot
			localparam logic signed [tpsik_pkg::ZW-1:0] ATZ =
				$signed({{(tpsik_pkg::ZW-tpsik_pkg::ATW){1'b0}}, tpsik_pkg::ATAN_Q16[i]});
			always_ff @(posedge clk) begin
				if (en) begin
					if (!sz_s[l][i][tpsik_pkg::ZW-1]) begin
						sx_s[l][i+1] <= sx_s[l][i] - (sy_s[l][i] >>> i);
						sy_s[l][i+1] <= sy_s[l][i] + (sx_s[l][i] >>> i);
						sz_s[l][i+1] <= sz_s[l][i] - ATZ;
					end else begin
						sx_s[l][i+1] <= sx_s[l][i] + (sy_s[l][i] >>> i);
						sy_s[l][i+1] <= sy_s[l][i] - (sx_s[l][i] >>> i);
						sz_s[l][i+1] <= sz_s[l][i] + ATZ;
					end
				end
			end
		end
		assign rprod[l] = $signed({1'b0, joint_radius_q}) * sy_s[l][tpsik_pkg::CORDIC_N];
		always_ff @(posedge clk) begin
			if (en) begin
				rs_s18[l] <= rprod[l][22+tpsik_pkg::HW-1:22];
			end
		end
	end

	assign sprod = rs_s18[1] * $signed({1'b0, tpsik_pkg::HALF_SQRT3});

	always_ff @(posedge clk) begin
		if (en) begin
			side_s19 <= sprod[30+tpsik_pkg::HW-1:30];
			half_s19 <= rs_s18[0] >>> 1;
			rsa_s19  <= rs_s18[0];
		end
	end

	assign base = $signed({3'b000, plate_height_q, 8'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			h_s20[0] <= base + rsa_s19;
			h_s20[1] <= base - half_s19 + side_s19;
			h_s20[2] <= base - half_s19 - side_s19;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_leg
		tpsik_leg u_leg (
			.clk (clk),
			.en  (en),
			.h   (h_s20[g]),
			.cfg (leg_cfg),
			.res (leg_res[g])
		);
	end

	always_comb begin
		priority if (tilt_s[tpsik_pkg::PIPE_LAT-1]) begin
			status_c = tpsik_pkg::ST_TILT;
		end else if (leg_res[0].bad || leg_res[1].bad || leg_res[2].bad) begin
			status_c = tpsik_pkg::ST_UNREACH;
		end else begin
			status_c = tpsik_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_valid <= 1'b0;
		end else if (en) begin
			servo_valid <= vld_s[tpsik_pkg::PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			servo.servo_a_angle <= leg_res[0].angle;
			servo.servo_b_angle <= leg_res[1].angle;
			servo.servo_c_angle <= leg_res[2].angle;
			servo.status        <= status_c;
		end
	end

	// a held output word freezes the whole valid chain
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved while output word held");

	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[tpsik_pkg::PIPE_LAT-1] |=> servo_valid)
		else $error("finished word not presented");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		en && !vld_s[tpsik_pkg::PIPE_LAT-1] |=> !servo_valid)
		else $error("output word without an item");

	a_tilt_status: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[tpsik_pkg::PIPE_LAT-1] && tilt_s[tpsik_pkg::PIPE_LAT-1]
		|=> servo.status == tpsik_pkg::ST_TILT)
		else $error("tilt flag lost");

endmodule
